// ===== rtl/ccrs_pkg.sv =====
// ----------------------------------------------------------------------------
// ccrs_pkg
// Shared types and constants of the character-class run segmenter.
// ----------------------------------------------------------------------------
package ccrs_pkg;

   localparam int CODE_W      = 16;
   localparam int CLASS_W     = 4;
   localparam int ACTION_W    = 2;
   localparam int RSP_DATA_W  = 8;
   localparam int QUEUE_DEPTH_DEF = 4;

   typedef enum logic [CLASS_W-1:0] {
      CLS_SPACE    = 4'd0,
      CLS_HANGUL   = 4'd1,
      CLS_SENTEND  = 4'd2,
      CLS_SEP      = 4'd3,
      CLS_BRACKET  = 4'd4,
      CLS_ELLIPSIS = 4'd5,
      CLS_DASH     = 4'd6,
      CLS_OTHER    = 4'd7,
      CLS_LATIN    = 4'd8,
      CLS_HAN      = 4'd9,
      CLS_DIGIT    = 4'd10
   } char_class_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_DROP    = 2'd0,
      ACT_APPEND  = 2'd1,
      ACT_NEWRUN  = 2'd2,
      ACT_NEWPART = 2'd3
   } action_type;

   // What the back end needs from one classified code unit.
   typedef struct packed {
      char_class_type cls;
      logic           is_dot;
   } seg_item_type;

   localparam logic [CODE_W-1:0] CODE_DOT = 16'h002e;

   localparam int NUM_BRACKET = 32;
   localparam logic [CODE_W-1:0] BRACKET_UNITS [NUM_BRACKET] = '{
      16'h0022, 16'h0027, 16'h0028, 16'h0029, 16'h003c, 16'h003e, 16'h005b, 16'h005d,
      16'h007b, 16'h007d, 16'h00ad, 16'h2015, 16'h2018, 16'h2019, 16'h201c, 16'h201d,
      16'h226a, 16'h226b, 16'h2500, 16'h3008, 16'h3009, 16'h300a, 16'h300b, 16'h300c,
      16'h300d, 16'h300e, 16'h300f, 16'h3010, 16'h3011, 16'h3014, 16'h3015, 16'hff0d
   };

   localparam int NUM_HAN = 11;
   localparam logic [CODE_W-1:0] HAN_LO [NUM_HAN] = '{
      16'h2e80, 16'h2e9b, 16'h2f00, 16'h3005, 16'h3021, 16'h3038,
      16'h3400, 16'h4e00, 16'hf900, 16'hfa70, 16'hd800
   };
   localparam logic [CODE_W-1:0] HAN_HI [NUM_HAN] = '{
      16'h2e99, 16'h2ef3, 16'h2fd5, 16'h3007, 16'h3029, 16'h303b,
      16'h4db5, 16'h9fcc, 16'hfa6d, 16'hfad9, 16'hdfff
   };

   localparam logic [CODE_W-1:0] HANGUL_LO = 16'hac00;
   localparam logic [CODE_W-1:0] HANGUL_END = 16'hd7a4;

endpackage

// ===== rtl/ccrs_classify.sv =====
// ----------------------------------------------------------------------------
// ccrs_classify
// Front end: accepts code units, sorts each into its character class and
// holds the result in one register stage ahead of the queue.
// ----------------------------------------------------------------------------
module ccrs_classify
   import ccrs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [CODE_W-1:0] req_code_unit,
   output logic              item_valid,
   input  logic              item_ready,
   output seg_item_type      item
);

   function automatic char_class_type classify(input logic [CODE_W-1:0] c);
      logic is_bracket;
      logic is_han;
      char_class_type res;
      is_bracket = 1'b0;
      is_han     = 1'b0;
      for (int i = 0; i < NUM_BRACKET; i++) begin
         if (c == BRACKET_UNITS[i]) is_bracket = 1'b1;
      end
      for (int i = 0; i < NUM_HAN; i++) begin
         if (c >= HAN_LO[i] && c <= HAN_HI[i]) is_han = 1'b1;
      end
      if (c == 16'h0020 || (c >= 16'h0009 && c <= 16'h000d)) begin
         res = CLS_SPACE;
      end else if (c >= 16'h0030 && c <= 16'h0039) begin
         res = CLS_DIGIT;
      end else if ((c >= 16'h0041 && c <= 16'h005a) || (c >= 16'h0061 && c <= 16'h007a)) begin
         res = CLS_LATIN;
      end else if (c >= HANGUL_LO && c < HANGUL_END) begin
         res = CLS_HANGUL;
      end else if (c == CODE_DOT || c == 16'h0021 || c == 16'h003f) begin
         res = CLS_SENTEND;
      end else if (c == 16'h002d || c == 16'h007e || c == 16'h223c) begin
         res = CLS_DASH;
      end else if (c == 16'h2026) begin
         res = CLS_ELLIPSIS;
      end else if (c == 16'h002c || c == 16'h003b || c == 16'h003a || c == 16'h002f ||
                   c == 16'h00b7) begin
         res = CLS_SEP;
      end else if (is_bracket) begin
         res = CLS_BRACKET;
      end else if (is_han) begin
         res = CLS_HAN;
      end else begin
         res = CLS_OTHER;
      end
      return res;
   endfunction

   logic         valid_ff, valid_in;
   seg_item_type item_ff, item_in;
   logic         take;

   assign req_tready = !valid_ff || item_ready;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in       = 1'b1;
         item_in.cls    = classify(req_code_unit);
         item_in.is_dot = (req_code_unit == CODE_DOT);
      end else if (item_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/ccrs_queue.sv =====
// ----------------------------------------------------------------------------
// ccrs_queue
// Short first-in first-out queue of classified items between the front end
// and the segmenting back end.
// ----------------------------------------------------------------------------
module ccrs_queue
   import ccrs_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  seg_item_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output seg_item_type out_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   seg_item_type     entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != CNT_FULL);
   assign out_valid = (count_ff != '0);
   assign out_item  = entries_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// ===== rtl/ccrs_segment.sv =====
// ----------------------------------------------------------------------------
// ccrs_segment
// Back end: keeps the open run and part state, decides the action for each
// classified item and holds the result in the output register.
// ----------------------------------------------------------------------------
module ccrs_segment
   import ccrs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           item_valid,
   output logic           item_ready,
   input  seg_item_type   item,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output char_class_type rsp_class,
   output action_type     rsp_action
);

   logic           part_empty_ff, part_empty_in;
   char_class_type run_class_ff, run_class_in;
   logic           out_valid_ff, out_valid_in;
   char_class_type out_class_ff, out_class_in;
   action_type     out_action_ff, out_action_in;
   action_type     act;
   logic           take;

   assign item_ready = !out_valid_ff || rsp_ready;
   assign take       = item_valid && item_ready;

   always_comb begin
      part_empty_in = part_empty_ff;
      run_class_in  = run_class_ff;
      if (item.cls == CLS_SPACE) begin
         act           = ACT_DROP;
         part_empty_in = 1'b1;
         run_class_in  = CLS_SPACE;
      end else if (part_empty_ff) begin
         act           = ACT_NEWPART;
         part_empty_in = 1'b0;
         run_class_in  = item.cls;
      end else if ((run_class_ff == CLS_DIGIT && item.is_dot) || run_class_ff == item.cls) begin
         // A dot after a digit run stays in that run; the run keeps its class.
         act = ACT_APPEND;
      end else begin
         act          = (run_class_ff == CLS_SENTEND) ? ACT_NEWPART : ACT_NEWRUN;
         run_class_in = item.cls;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_class_in  = out_class_ff;
      out_action_in = out_action_ff;
      if (take) begin
         out_valid_in  = 1'b1;
         out_class_in  = item.cls;
         out_action_in = act;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         part_empty_ff <= 1'b1;
         run_class_ff  <= CLS_SPACE;
         out_valid_ff  <= 1'b0;
      end else begin
         if (take) begin
            part_empty_ff <= part_empty_in;
            run_class_ff  <= run_class_in;
         end
         out_valid_ff <= out_valid_in;
      end
      out_class_ff  <= out_class_in;
      out_action_ff <= out_action_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_class  = out_class_ff;
   assign rsp_action = out_action_ff;

endmodule

// ===== rtl/char_class_run_segmenter.sv =====
// ----------------------------------------------------------------------------
// char_class_run_segmenter
// Classifies UTF-16 code units and groups them into runs and parts.
// ----------------------------------------------------------------------------
// The block takes one code unit per clock and returns one result per code
// unit, in order, at a sustained rate of one item per cycle while the result
// side takes every result. On its way each item passes the classifier
// register, one entry of the item queue and the output register. The queue
// holds QUEUE_DEPTH classified items. When the result side stops taking items
// in the middle of a steady stream, the input still takes QUEUE_DEPTH - 1 more
// items before it stalls. Each result carries the unit's character class and
// whether the unit was dropped as whitespace, appended to the open run, began
// a new run, or began the first run of a part.
module char_class_run_segmenter
   import ccrs_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [CODE_W-1:0]     req_tdata,   // [15:0] code_unit
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [3:0] char_class, [5:4] action
);

   logic           fr_valid, fr_ready;
   seg_item_type   fr_item;
   logic           bk_valid, bk_ready;
   seg_item_type   bk_item;
   char_class_type rsp_class;
   action_type     rsp_action;

   ccrs_classify u_classify (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_code_unit (req_tdata),
      .item_valid    (fr_valid),
      .item_ready    (fr_ready),
      .item          (fr_item)
   );

   ccrs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_item   (fr_item),
      .out_valid (bk_valid),
      .out_ready (bk_ready),
      .out_item  (bk_item)
   );

   ccrs_segment u_segment (
      .clock      (clock),
      .reset      (reset),
      .item_valid (bk_valid),
      .item_ready (bk_ready),
      .item       (bk_item),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_class  (rsp_class),
      .rsp_action (rsp_action)
   );

   assign rsp_tdata = {{(RSP_DATA_W - CLASS_W - ACTION_W){1'b0}}, rsp_action, rsp_class};

endmodule

// ===== rtl/ccrs_checker.sv =====
// ----------------------------------------------------------------------------
// ccrs_checker
// Port-level checks of the character-class run segmenter.
// ----------------------------------------------------------------------------
module ccrs_checker
   import ccrs_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [CLASS_W-1:0]  cls;
   logic [ACTION_W-1:0] act;

   assign cls = rsp_tdata[CLASS_W-1:0];
   assign act = rsp_tdata[CLASS_W+ACTION_W-1:CLASS_W];

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

   // Whitespace is always dropped, and nothing else ever is.
   a_space_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((cls == CLS_SPACE) == (act == ACT_DROP)))
      else $error("drop action does not match whitespace class");

   a_class_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> cls <= CLS_DIGIT)
      else $error("class code out of range");

endmodule

bind char_class_run_segmenter ccrs_checker u_ccrs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
